>>> design/bgis_pkg.sv
// Battery gauge / idle-sleep package: field widths, command and state codes,
// conversion constants, the sequencer control-word type and its program ROM.
// No dependencies.
package bgis_pkg;

	localparam int CMD_W      = 2;
	localparam int ADC_W      = 12;
	localparam int MV_W       = 14;
	localparam int PCT_W      = 7;
	localparam int BST_W      = 2;
	localparam int SUM_W      = 16;
	localparam int CNT_W      = 4;
	localparam int IDLE_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// datapath widths
	localparam int A_W  = 28;            // working value, holds avg*2200
	localparam int Q_W  = 18;            // quotient
	localparam int MA_W = 22;            // multiplier operand a
	localparam int MB_W = 17;            // multiplier operand b (constant)
	localparam int P_W  = MA_W + MB_W;   // product
	localparam int UPC_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_ACTIVITY = 2'd2,
		CMD_SLEEP    = 2'd3
	} cmd_t;

	typedef enum logic [BST_W-1:0] {
		BS_FULL    = 2'd0,
		BS_DISCH   = 2'd1,
		BS_UNKNOWN = 2'd2
	} batt_state_t;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TO = 1'b1;

	localparam logic [PCT_W-1:0]  THR_RESET = 7'd20;
	localparam logic [IDLE_W-1:0] TO_RESET  = 16'd300;

	// conversion chain constants
	localparam logic [MB_W-1:0] K_MV_SCALE = 17'd2200;
	localparam logic [MB_W-1:0] K_ADC_FS   = 17'd4095;
	localparam logic [MB_W-1:0] K_DIV_NUM  = 17'd115;
	localparam logic [MB_W-1:0] K_DIV_DEN  = 17'd24;
	localparam logic [MB_W-1:0] RCP_4095   = 17'd1024;   // (x>>6)*1024>>16 = x>>12
	localparam logic [MB_W-1:0] RCP_24     = 17'd43690;  // floor(2^20/24)

	// voltage thresholds (mV)
	localparam logic [MV_W-1:0] V_FULL    = 14'd4200;
	localparam logic [MV_W-1:0] V_KNEE_HI = 14'd4000;
	localparam logic [MV_W-1:0] V_KNEE_LO = 14'd3700;
	localparam logic [MV_W-1:0] V_EMPTY   = 14'd3300;
	localparam logic [MV_W-1:0] V_CRIT    = 14'd3100;

	localparam logic [PCT_W-1:0] LV_FULL = 7'd100;
	localparam logic [PCT_W-1:0] LV_MID  = 7'd20;
	localparam logic [PCT_W-1:0] LV_HIGH = 7'd60;
	// reciprocals over 2^16, exact for the narrow segment ranges
	localparam logic [13:0] LV_RCP_20 = 14'd3277;    // 1/20
	localparam logic [13:0] LV_RCP_75 = 14'd8739;    // 40/300
	localparam logic [13:0] LV_RCP_5  = 14'd13108;   // 1/5

	typedef struct packed {
		logic [MV_W-1:0]  batt_mv;
		logic [PCT_W-1:0] level_pct;
		batt_state_t      battery_state;
		logic             asleep;
		logic             update_done;
		logic             critical_event;
		logic             low_event;
		logic             sleep_enter_event;
		logic             wake_event;
	} res_t;

	typedef enum logic [2:0] {
		UOP_LOAD,     // a <= sample sum
		UOP_MUL_A,    // p <= (a >> pre) * k
		UOP_QEST,     // q <= p >> sh
		UOP_MUL_Q,    // p <= q * k
		UOP_REM,      // r <= a - p
		UOP_FIX,      // while r >= k: q++, r -= k
		UOP_MOVE,     // a <= p
		UOP_FINISH    // commit voltage, level, flags
	} uop_t;

	typedef enum logic [2:0] {
		KC_N, KC_RCP_N, KC_RCP_4095, KC_4095, KC_2200, KC_115, KC_RCP_24, KC_24
	} kc_t;

	typedef struct packed {
		uop_t       op;
		kc_t        kc;
		logic [2:0] pre;
		logic [4:0] sh;
	} uword_t;

	localparam logic [UPC_W-1:0] UC_LAST = 5'd20;

	function automatic uword_t uc_rom(logic [UPC_W-1:0] pc);
		uword_t w;
		w = '{op: UOP_FINISH, kc: KC_N, pre: 3'd0, sh: 5'd0};
		case (pc)
			// avg = sum / N
			5'd0:  w = '{op: UOP_LOAD,  kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd1:  w = '{op: UOP_MUL_A, kc: KC_RCP_N,    pre: 3'd0, sh: 5'd0};
			5'd2:  w = '{op: UOP_QEST,  kc: KC_N,        pre: 3'd0, sh: 5'd16};
			5'd3:  w = '{op: UOP_MUL_Q, kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd4:  w = '{op: UOP_REM,   kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd5:  w = '{op: UOP_FIX,   kc: KC_N,        pre: 3'd0, sh: 5'd0};
			// mv = avg * 2200 / 4095
			5'd6:  w = '{op: UOP_MUL_Q, kc: KC_2200,     pre: 3'd0, sh: 5'd0};
			5'd7:  w = '{op: UOP_MOVE,  kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd8:  w = '{op: UOP_MUL_A, kc: KC_RCP_4095, pre: 3'd6, sh: 5'd0};
			5'd9:  w = '{op: UOP_QEST,  kc: KC_N,        pre: 3'd0, sh: 5'd16};
			5'd10: w = '{op: UOP_MUL_Q, kc: KC_4095,     pre: 3'd0, sh: 5'd0};
			5'd11: w = '{op: UOP_REM,   kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd12: w = '{op: UOP_FIX,   kc: KC_4095,     pre: 3'd0, sh: 5'd0};
			// v = mv * 115 / 24
			5'd13: w = '{op: UOP_MUL_Q, kc: KC_115,      pre: 3'd0, sh: 5'd0};
			5'd14: w = '{op: UOP_MOVE,  kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd15: w = '{op: UOP_MUL_A, kc: KC_RCP_24,   pre: 3'd0, sh: 5'd0};
			5'd16: w = '{op: UOP_QEST,  kc: KC_N,        pre: 3'd0, sh: 5'd20};
			5'd17: w = '{op: UOP_MUL_Q, kc: KC_24,       pre: 3'd0, sh: 5'd0};
			5'd18: w = '{op: UOP_REM,   kc: KC_N,        pre: 3'd0, sh: 5'd0};
			5'd19: w = '{op: UOP_FIX,   kc: KC_24,       pre: 3'd0, sh: 5'd0};
			5'd20: w = '{op: UOP_FINISH, kc: KC_N,       pre: 3'd0, sh: 5'd0};
			default: w = '{op: UOP_FINISH, kc: KC_N,     pre: 3'd0, sh: 5'd0};
		endcase
		return w;
	endfunction

	// three linear segments, clamped to 0 below V_EMPTY and 100 at V_FULL
	function automatic logic [PCT_W-1:0] level_of(logic [MV_W-1:0] v);
		logic [8:0]       d;
		logic [13:0]      k;
		logic [22:0]      p;
		logic [PCT_W-1:0] base;
		logic [PCT_W-1:0] lvl;
		d    = '0;
		k    = '0;
		base = '0;
		if (v < V_KNEE_LO) begin
			d = 9'(v - V_EMPTY);
			k = LV_RCP_20;
		end else if (v < V_KNEE_HI) begin
			d    = 9'(v - V_KNEE_LO);
			k    = LV_RCP_75;
			base = LV_MID;
		end else begin
			d    = 9'(v - V_KNEE_HI);
			k    = LV_RCP_5;
			base = LV_HIGH;
		end
		p = 23'(d) * 23'(k);
		if (v >= V_FULL) begin
			lvl = LV_FULL;
		end else if (v < V_EMPTY) begin
			lvl = '0;
		end else begin
			lvl = base + p[22:16];
		end
		return lvl;
	endfunction

endpackage

>>> design/bgis_if.sv
// Channel interfaces of the battery gauge: input word, result word and
// register write channel. Depends on bgis_pkg.
interface bgis_item_if;
	import bgis_pkg::*;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [ADC_W-1:0] adc_raw;
	logic             read_ok;
	modport source(output valid, command, adc_raw, read_ok, input ready);
	modport sink(input valid, command, adc_raw, read_ok, output ready);
endinterface

interface bgis_result_if;
	import bgis_pkg::*;
	logic             valid;
	logic             ready;
	logic [MV_W-1:0]  batt_mv;
	logic [PCT_W-1:0] level_pct;
	logic [BST_W-1:0] battery_state;
	logic             asleep;
	logic             update_done;
	logic             critical_event;
	logic             low_event;
	logic             sleep_enter_event;
	logic             wake_event;
	modport source(output valid, batt_mv, level_pct, battery_state, asleep, update_done,
		critical_event, low_event, sleep_enter_event, wake_event, input ready);
	modport sink(input valid, batt_mv, level_pct, battery_state, asleep, update_done,
		critical_event, low_event, sleep_enter_event, wake_event, output ready);
endinterface

interface bgis_cfg_if;
	import bgis_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> design/battery_gauge_idle_sleep_unit.sv
// Battery gauge with idle-time sleep control. Depends on bgis_pkg, bgis_if.
// Ticks, activity, sleep requests and samples that do not close a group: one word
// per cycle when the output is not stalled, status via the result and output registers.
// A sample that closes a group runs the conversion program on one shared multiplier:
// 21 steps, correction steps repeating while r >= k, then result and output registers.
// Async reset (arst_n low): block awake, sums, levels and idle count zero,
// threshold 20 %, timeout 300 s.
module battery_gauge_idle_sleep_unit #(
	parameter int SAMPLES_PER_UPDATE = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	bgis_item_if.sink           item,
	bgis_result_if.source       result,
	bgis_cfg_if.sink            cfg
);
	import bgis_pkg::*;

	localparam int RCP_N = (1 << 16) / SAMPLES_PER_UPDATE;

	typedef enum logic {ST_IDLE, ST_RUN} st_t;

	st_t               state_q;
	logic [UPC_W-1:0]  pc_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MV_W-1:0]   last_v_q;
	logic [PCT_W-1:0]  last_lvl_q;
	batt_state_t       last_st_q;
	logic              sleep_q;
	logic [IDLE_W-1:0] idle_q;
	logic [PCT_W-1:0]  thr_q;
	logic [IDLE_W-1:0] to_q;
	res_t              res_q;
	logic              res_valid_q;
	res_t              out_q;
	logic              out_valid_q;

	logic [A_W-1:0]    a_q;
	logic [Q_W-1:0]    q_q;
	logic [A_W-1:0]    r_q;
	logic [P_W-1:0]    p_q;

	uword_t            uw;
	logic [MB_W-1:0]   kval;
	logic [MA_W-1:0]   mul_a;
	logic [P_W-1:0]    prod;
	logic              fix_more;
	logic              out_load;
	logic              res_load;
	logic              item_acc;
	cmd_t              cmd;
	logic [SUM_W-1:0]  nx_sum;
	logic [CNT_W-1:0]  nx_cnt;
	logic              grp;
	logic              nx_sleep;
	logic              ev_enter;
	logic              ev_wake;
	res_t              simple_res;
	logic [MV_W-1:0]   fin_v;
	logic [PCT_W-1:0]  fin_lvl;
	batt_state_t       fin_st;
	logic              fin_enter;
	res_t              fin_res;

	assign uw = uc_rom(pc_q);

	always_comb begin
		case (uw.kc)
			KC_N:        kval = MB_W'(SAMPLES_PER_UPDATE);
			KC_RCP_N:    kval = MB_W'(RCP_N);
			KC_RCP_4095: kval = RCP_4095;
			KC_4095:     kval = K_ADC_FS;
			KC_2200:     kval = K_MV_SCALE;
			KC_115:      kval = K_DIV_NUM;
			KC_RCP_24:   kval = RCP_24;
			KC_24:       kval = K_DIV_DEN;
			default:     kval = '0;
		endcase
	end

	assign mul_a    = (uw.op == UOP_MUL_A) ? MA_W'(a_q >> uw.pre) : MA_W'(q_q);
	assign prod     = P_W'(mul_a) * P_W'(kval);
	assign fix_more = (r_q >= A_W'(kval));

	// handshakes
	assign out_load   = res_valid_q && (!out_valid_q || result.ready);
	assign item.ready = (state_q == ST_IDLE) && (!res_valid_q || out_load);
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// accept-cycle decode
	assign cmd    = cmd_t'(item.command);
	assign nx_sum = item.read_ok ? sum_q + SUM_W'(item.adc_raw) : sum_q;
	assign nx_cnt = cnt_q + 1'b1;
	assign grp    = (nx_cnt >= CNT_W'(SAMPLES_PER_UPDATE));

	// a fresh status word enters the result register
	assign res_load = (state_q == ST_IDLE && item_acc && !(cmd == CMD_SAMPLE && grp)) ||
		(state_q == ST_RUN && uw.op == UOP_FINISH);

	always_comb begin
		nx_sleep = sleep_q;
		ev_enter = 1'b0;
		ev_wake  = 1'b0;
		case (cmd)
			CMD_ACTIVITY: begin
				nx_sleep = 1'b0;
				ev_wake  = sleep_q;
			end
			CMD_SLEEP: begin
				nx_sleep = 1'b1;
				ev_enter = !sleep_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		simple_res = '{batt_mv: last_v_q, level_pct: last_lvl_q,
			battery_state: last_st_q, asleep: nx_sleep, update_done: 1'b0,
			critical_event: 1'b0, low_event: 1'b0, sleep_enter_event: ev_enter,
			wake_event: ev_wake};
	end

	// end of the conversion program
	assign fin_v   = q_q[MV_W-1:0];
	assign fin_lvl = level_of(fin_v);

	always_comb begin
		if (fin_v >= V_FULL) begin
			fin_st = BS_FULL;
		end else if (fin_v > V_KNEE_LO) begin
			fin_st = BS_DISCH;
		end else if (fin_v < V_CRIT) begin
			fin_st = BS_UNKNOWN;
		end else begin
			fin_st = BS_DISCH;
		end
	end

	assign fin_enter = (to_q != '0) && !sleep_q && (idle_q >= to_q);

	always_comb begin
		fin_res = '{batt_mv: fin_v, level_pct: fin_lvl, battery_state: fin_st,
			asleep: sleep_q | fin_enter, update_done: 1'b1,
			critical_event: fin_v < V_CRIT, low_event: fin_lvl <= thr_q,
			sleep_enter_event: fin_enter, wake_event: 1'b0};
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (uw.op)
				UOP_LOAD:  a_q <= A_W'(sum_q);
				UOP_MUL_A: p_q <= prod;
				UOP_MUL_Q: p_q <= prod;
				UOP_QEST:  q_q <= Q_W'(p_q >> uw.sh);
				UOP_REM:   r_q <= a_q - A_W'(p_q);
				UOP_FIX: begin
					if (fix_more) begin
						q_q <= q_q + 1'b1;
						r_q <= r_q - A_W'(kval);
					end
				end
				UOP_MOVE:  a_q <= A_W'(p_q);
				default: ;
			endcase
		end
	end

	// control, architectural state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			last_v_q    <= '0;
			last_lvl_q  <= '0;
			last_st_q   <= BS_FULL;
			sleep_q     <= 1'b0;
			idle_q      <= '0;
			thr_q       <= THR_RESET;
			to_q        <= TO_RESET;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_LOW_THR:  thr_q <= cfg.data[PCT_W-1:0];
					REG_SLEEP_TO: to_q <= cfg.data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_load) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						case (cmd)
							CMD_SAMPLE: begin
								sum_q <= nx_sum;
								if (grp) begin
									cnt_q   <= '0;
									pc_q    <= '0;
									state_q <= ST_RUN;
								end else begin
									cnt_q <= nx_cnt;
								end
							end
							CMD_TICK: begin
								if (idle_q != '1) begin
									idle_q <= idle_q + 1'b1;
								end
							end
							CMD_ACTIVITY: idle_q <= '0;
							default: ;
						endcase
						sleep_q <= nx_sleep;
						if (!(cmd == CMD_SAMPLE && grp)) begin
							res_q <= simple_res;
						end
					end
				end
				ST_RUN: begin
					case (uw.op)
						UOP_LOAD: begin
							sum_q <= '0;
							pc_q  <= pc_q + 1'b1;
						end
						UOP_FIX: begin
							if (!fix_more) begin
								pc_q <= pc_q + 1'b1;
							end
						end
						UOP_FINISH: begin
							last_v_q    <= fin_v;
							last_lvl_q  <= fin_lvl;
							last_st_q   <= fin_st;
							sleep_q     <= sleep_q | fin_enter;
							res_q       <= fin_res;
							state_q     <= ST_IDLE;
						end
						default: pc_q <= pc_q + 1'b1;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid             = out_valid_q;
	assign result.batt_mv           = out_q.batt_mv;
	assign result.level_pct         = out_q.level_pct;
	assign result.battery_state     = out_q.battery_state;
	assign result.asleep            = out_q.asleep;
	assign result.update_done       = out_q.update_done;
	assign result.critical_event    = out_q.critical_event;
	assign result.low_event         = out_q.low_event;
	assign result.sleep_enter_event = out_q.sleep_enter_event;
	assign result.wake_event        = out_q.wake_event;

	// sample count never reaches the group size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SAMPLES_PER_UPDATE))
		else $error("sample count out of range");

	// sequencer stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> pc_q <= UC_LAST)
		else $error("program counter past end of program");

	// a fresh update result implies the accumulator was cleared
	a_upd_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) && res_q.update_done |-> sum_q == '0 && cnt_q == '0)
		else $error("update finished without clearing sample group");

	// idle time is frozen while the conversion program runs
	a_idle_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |=> $stable(idle_q))
		else $error("idle count changed during conversion");

endmodule

>>> dv/battery_gauge_idle_sleep_unit_tb.sv
// Self-checking testbench for battery_gauge_idle_sleep_unit: directed and random
// words, idle and stall mixes, and a long result hold-off with an inline predictor.
// Depends on bgis_pkg, bgis_if and the unit itself.
`timescale 1ns / 1ps

module battery_gauge_idle_sleep_unit_tb;
	import bgis_pkg::*;

	localparam int GROUP        = 10;
	localparam int DRAIN_CYCLES = 48;    // longest group conversion plus output stage
	localparam int MAX_REPORTS  = 60;

	logic clk = 1'b0;
	logic arst_n;

	bgis_item_if   item();
	bgis_result_if result();
	bgis_cfg_if    cfg();

	battery_gauge_idle_sleep_unit #(
		.SAMPLES_PER_UPDATE(GROUP)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted gauge state and register copies
	logic [SUM_W-1:0]  acc_sum;
	logic [CNT_W-1:0]  acc_count;
	logic [MV_W-1:0]   gauge_mv;
	logic [PCT_W-1:0]  gauge_pct;
	batt_state_t       gauge_state;
	logic              gauge_asleep;
	logic [IDLE_W-1:0] idle_secs;
	logic [PCT_W-1:0]  low_thr;
	logic [IDLE_W-1:0] sleep_to;

	res_t        pending_status[$];
	int unsigned sample_plan[$];
	int unsigned knee_mv[5];
	int unsigned knee_avg[5];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          hold_request   = 0;
	int          hold_left      = 0;

	int n_errors = 0;
	int n_words = 0, n_updates = 0, n_crit = 0, n_low = 0, n_sleeps = 0, n_wakes = 0;

	function automatic int unsigned volts_of(int unsigned avg);
		int unsigned mv;
		mv = (avg * 2200) / 4095;
		return (mv * 115) / 24;
	endfunction

	function automatic logic [PCT_W-1:0] pct_from_mv(int unsigned v);
		if (v >= 4200) return PCT_W'(100);
		if (v < 3300) return '0;
		if (v < 3700) return PCT_W'((v - 3300) / 20);
		if (v < 4000) return PCT_W'(20 + ((v - 3700) * 40) / 300);
		return PCT_W'(60 + (v - 4000) / 5);
	endfunction

	// advances the predicted state by one word and returns the status word it yields
	function automatic res_t predict_gauge(cmd_t c, logic [ADC_W-1:0] raw, logic ok);
		res_t        r;
		int unsigned v;
		r = '0;
		case (c)
			CMD_SAMPLE: begin
				if (ok)
					acc_sum = acc_sum + SUM_W'(raw);
				acc_count = acc_count + 1'b1;
				if (acc_count >= GROUP) begin
					v = volts_of(acc_sum / GROUP);
					acc_sum   = '0;
					acc_count = '0;
					gauge_mv  = MV_W'(v);
					gauge_pct = pct_from_mv(gauge_mv);
					if (gauge_mv >= 4200) begin
						gauge_state = BS_FULL;
					end else if (gauge_mv > 3700) begin
						gauge_state = BS_DISCH;
					end else if (gauge_mv < 3100) begin
						gauge_state = BS_UNKNOWN;
						r.critical_event = 1'b1;
					end else begin
						gauge_state = BS_DISCH;
					end
					r.low_event   = (gauge_pct <= low_thr);
					r.update_done = 1'b1;
					if (sleep_to != 0 && !gauge_asleep && idle_secs >= sleep_to) begin
						gauge_asleep        = 1'b1;
						r.sleep_enter_event = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				if (idle_secs != '1)
					idle_secs = idle_secs + 1'b1;
			end
			CMD_ACTIVITY: begin
				idle_secs = '0;
				if (gauge_asleep) begin
					gauge_asleep = 1'b0;
					r.wake_event = 1'b1;
				end
			end
			default: begin
				if (!gauge_asleep) begin
					gauge_asleep        = 1'b1;
					r.sleep_enter_event = 1'b1;
				end
			end
		endcase
		r.batt_mv       = gauge_mv;
		r.level_pct     = gauge_pct;
		r.battery_state = gauge_state;
		r.asleep        = gauge_asleep;
		return r;
	endfunction

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_word(cmd_t c, logic [ADC_W-1:0] raw, logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid   <= 1'b0;
			item.command <= CMD_W'($urandom_range(3));
			item.adc_raw <= ADC_W'($urandom);
			item.read_ok <= 1'($urandom);
			@(negedge clk);
		end
		item.valid   <= 1'b1;
		item.command <= c;
		item.adc_raw <= raw;
		item.read_ok <= ok;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		pending_status.push_back(predict_gauge(c, raw, ok));
		n_words++;
		@(negedge clk);
	endtask

	// drop valid, let every status word come back, then give the block time to settle
	task automatic wait_idle();
		item.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		if (idx == REG_LOW_THR)
			low_thr = val[PCT_W-1:0];
		else if (idx == REG_SLEEP_TO)
			sleep_to = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_status.size() == 0) begin
				n_errors++;
				$error("status word with nothing outstanding");
			end else begin
				want = pending_status.pop_front();
				check_field("batt_mv", want.batt_mv, result.batt_mv);
				check_field("level_pct", want.level_pct, result.level_pct);
				check_field("battery_state", want.battery_state, result.battery_state);
				check_field("asleep", want.asleep, result.asleep);
				check_field("update_done", want.update_done, result.update_done);
				check_field("critical_event", want.critical_event, result.critical_event);
				check_field("low_event", want.low_event, result.low_event);
				check_field("sleep_enter_event", want.sleep_enter_event,
					result.sleep_enter_event);
				check_field("wake_event", want.wake_event, result.wake_event);
			end
			n_updates += result.update_done;
			n_crit    += result.critical_event;
			n_low     += result.low_event;
			n_sleeps  += result.sleep_enter_event;
			n_wakes   += result.wake_event;
		end
	end

	// mode changes without any sample traffic
	task automatic test_modes();
		send_word(CMD_TICK, '1, 1'b0);
		send_word(CMD_TICK, '0, 1'b1);
		send_word(CMD_ACTIVITY, '1, 1'b1);     // awake: only clears idle count
		send_word(CMD_SLEEP, '0, 1'b0);
		send_word(CMD_SLEEP, '1, 1'b1);        // already asleep: no event
		send_word(CMD_TICK, 12'hA5A, 1'b0);
		send_word(CMD_ACTIVITY, 12'h5A5, 1'b0);
		wait_idle();
	endtask

	// full-scale group while asleep, then a group of zeros and failed reads
	task automatic test_sample_extremes();
		send_word(CMD_SLEEP, '0, 1'b0);
		repeat (GROUP) send_word(CMD_SAMPLE, '1, 1'b1);
		for (int i = 0; i < GROUP; i++)
			send_word(CMD_SAMPLE, (i % 2) ? '1 : '0, (i % 2) ? 1'b0 : 1'b1);
		send_word(CMD_ACTIVITY, '0, 1'b0);
		wait_idle();
	endtask

	// sleep entry on update once the idle count reaches the timeout; zero disables it
	task automatic test_idle_timeout();
		write_register(REG_LOW_THR, CFG_DATA_W'(100));
		write_register(REG_SLEEP_TO, CFG_DATA_W'(2));
		send_word(CMD_ACTIVITY, '0, 1'b1);
		repeat (GROUP - 1) send_word(CMD_SAMPLE, 12'd1500, 1'b1);
		send_word(CMD_TICK, '0, 1'b0);
		send_word(CMD_TICK, '0, 1'b0);         // at timeout, tick alone stays awake
		send_word(CMD_SAMPLE, 12'd1500, 1'b1);
		send_word(CMD_ACTIVITY, '0, 1'b0);
		wait_idle();
		write_register(REG_SLEEP_TO, '0);
		repeat (3) send_word(CMD_TICK, '0, 1'b0);
		repeat (GROUP) send_word(CMD_SAMPLE, 12'd1400, 1'b1);
		wait_idle();
	endtask

	// widest timeout must not fire after a short idle stretch
	task automatic test_max_timeout();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_register(REG_SLEEP_TO, '1);
		send_word(CMD_ACTIVITY, '0, 1'b0);
		repeat (40) send_word(CMD_TICK, '0, 1'b0);
		repeat (GROUP) send_word(CMD_SAMPLE, 12'd1600, 1'b1);
		send_word(CMD_ACTIVITY, '0, 1'b0);
		wait_idle();
	endtask

	// mostly well-formed sample groups, some aimed at segment knees, mixed with mode words
	task automatic test_random_phase(int n, int unsigned s_pct, int unsigned r_pct);
		int unsigned      sel, target, jit;
		int               s;
		logic [ADC_W-1:0] raw;
		logic             ok;
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		for (int i = 0; i < n; i++) begin
			if (i % (n / 2) == 0) begin
				wait_idle();
				sel = $urandom_range(99);
				raw = (sel < 15) ? '0 : (sel < 30) ? ADC_W'(100) : (sel < 45) ? ADC_W'(127)
					: ADC_W'($urandom_range(127));
				write_register(REG_LOW_THR,
					{(CFG_DATA_W - PCT_W)'($urandom), raw[PCT_W-1:0]});
				sel = $urandom_range(99);
				write_register(REG_SLEEP_TO, (sel < 15) ? '0 : (sel < 25) ? '1
					: (sel < 35) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(1, 10)));
			end
			sel = $urandom_range(99);
			if (sel < 68) begin
				if (sample_plan.size() == 0) begin
					sel = $urandom_range(99);
					jit = 16;
					if (sel < 35) begin
						target = knee_avg[$urandom_range(4)] + $urandom_range(4) - 2;
						jit    = 0;
					end else if (sel < 85) begin
						target = $urandom_range(1800, 1000);
					end else begin
						target = $urandom_range(4095);
					end
					for (int j = acc_count; j < GROUP; j++) begin
						s = int'(target) + int'($urandom_range(2 * jit)) - int'(jit);
						sample_plan.push_back((s < 0) ? 0 : (s > 4095) ? 4095 : s);
					end
				end
				raw = ADC_W'(sample_plan.pop_front());
				ok  = ($urandom_range(99) >= 6);
				if (!ok)
					raw = ADC_W'($urandom);
				send_word(CMD_SAMPLE, raw, ok);
			end else if (sel < 84) begin
				send_word(CMD_TICK, ADC_W'($urandom), 1'($urandom));
			end else if (sel < 92) begin
				send_word(CMD_ACTIVITY, ADC_W'($urandom), 1'($urandom));
			end else if (sel < 97) begin
				send_word(CMD_SLEEP, ADC_W'($urandom), 1'($urandom));
			end else begin
				send_word(cmd_t'($urandom_range(3)), ADC_W'($urandom), 1'($urandom));
			end
		end
		wait_idle();
	endtask

	// results held off while the sender keeps pushing, so the input side must stall
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 300;
		for (int i = 0; i < 60; i++) begin
			if ($urandom_range(3) == 0)
				send_word(CMD_TICK, '0, 1'b0);
			else
				send_word(CMD_SAMPLE, ADC_W'($urandom_range(1700, 1200)), 1'b1);
		end
		wait_idle();
	endtask

	initial begin
		item.valid    = 1'b0;
		item.command  = CMD_SAMPLE;
		item.adc_raw  = '0;
		item.read_ok  = 1'b0;
		cfg.valid     = 1'b0;
		cfg.index     = REG_LOW_THR;
		cfg.data      = '0;
		result.ready  = 1'b0;
		arst_n        = 1'b0;
		acc_sum       = '0;
		acc_count     = '0;
		gauge_mv      = '0;
		gauge_pct     = '0;
		gauge_state   = BS_FULL;
		gauge_asleep  = 1'b0;
		idle_secs     = '0;
		low_thr       = THR_RESET;
		sleep_to      = TO_RESET;
		knee_mv = '{V_CRIT, V_EMPTY, V_KNEE_LO, V_KNEE_HI, V_FULL};
		// lowest average that reaches each knee
		for (int k = 0; k < 5; k++) begin
			knee_avg[k] = 0;
			while (knee_avg[k] < 4095 && volts_of(knee_avg[k]) < knee_mv[k])
				knee_avg[k]++;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_modes();
		test_sample_extremes();
		test_idle_timeout();
		test_max_timeout();
		test_random_phase(190, 0, 0);
		test_random_phase(190, 72, 0);
		test_random_phase(190, 0, 72);
		test_random_phase(190, 12, 12);
		test_backpressure();

		$display("covered %0d words: %0d group updates, %0d critical, %0d low", n_words,
			n_updates, n_crit, n_low);
		$display("%0d sleep entries and %0d wakes, widest timeout, long result stall",
			n_sleeps, n_wakes);
		if (n_errors == 0)
			$display("battery_gauge_idle_sleep_unit_tb: done, clean");
		else
			$display("battery_gauge_idle_sleep_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("battery_gauge_idle_sleep_unit_tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
design/bgis_pkg.sv
design/bgis_if.sv
design/battery_gauge_idle_sleep_unit.sv
dv/battery_gauge_idle_sleep_unit_tb.sv
